FILE: rtl/dqc_pkg.sv
// Shared types and constants of the deque-with-cursor block.
// Used by dqc_store, dqc_ctrl and double_ended_queue_with_cursor_core.
package dqc_pkg;

    localparam int DQC_CAPACITY = 16;
    localparam int WORD_W       = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_L = 3'd0,
        CMD_PUSH_R = 3'd1,
        CMD_POP_L  = 3'd2,
        CMD_POP_R  = 3'd3,
        CMD_CUR_L  = 3'd4,
        CMD_CUR_R  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_AT_END = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_FILL = 1'b1
    } t_state;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped;
        t_status                  status;
        logic signed [WORD_W-1:0] left;
        logic signed [WORD_W-1:0] right;
        logic signed [WORD_W-1:0] cursor;
        logic                     empty;
    } t_res;

endpackage

FILE: rtl/dqc_store.sv
// Word memory of the deque: one write port, one read port, registered read data.
// Depends on dqc_pkg for the word width.
module dqc_store
    import dqc_pkg::*;
#(
    parameter int DEPTH = DQC_CAPACITY,
    parameter int AW    = $clog2(DQC_CAPACITY)
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [WORD_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [WORD_W-1:0] o_rd_data
);

    logic signed [WORD_W-1:0] r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/dqc_ctrl.sv
// Command sequencer of the deque: end slots, count, cursor and shadow copies of the
// left, right and cursor words. Drives the ports of dqc_store; depends on dqc_pkg.
module dqc_ctrl
    import dqc_pkg::*;
#(
    parameter int CAPACITY = DQC_CAPACITY,
    parameter int AW       = $clog2(DQC_CAPACITY),
    parameter int CW       = $clog2(DQC_CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  logic [2:0]               i_cmd,
    input  logic signed [WORD_W-1:0] i_val,
    output logic                     o_idle,
    output logic                     o_res_valid,
    output t_res                     o_res,
    output logic [CW-1:0]            o_count,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic signed [WORD_W-1:0] o_wr_data,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr,
    input  logic signed [WORD_W-1:0] i_rd_data
);

    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);

    t_state r_state, n_state;
    logic [AW-1:0] r_left, n_left;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_count, n_count;
    logic signed [WORD_W-1:0] r_wl, n_wl, r_wr, n_wr, r_wc, n_wc;
    logic signed [WORD_W-1:0] r_popped, n_popped;
    t_status r_status, n_status;
    logic r_ld_l, n_ld_l, r_ld_r, n_ld_r, r_ld_c, n_ld_c;

    logic [AW-1:0] w_left_next, w_left_prev, w_right, w_right_prev;
    logic [AW-1:0] w_cur_next, w_cur_prev, w_push_r;
    logic [SW-1:0] w_sum_r, w_sum_p;
    logic [CW-1:0] w_cnt_m1;
    logic w_full, w_empty;

    always_comb begin
        w_full      = (r_count == CAP_C);
        w_empty     = (r_count == '0);
        w_cnt_m1    = w_empty ? '0 : r_count - CW'(1);
        w_left_next = (r_left == LAST_SLOT) ? '0 : r_left + AW'(1);
        w_left_prev = (r_left == '0) ? LAST_SLOT : r_left - AW'(1);
        w_cur_next  = (r_cursor == LAST_SLOT) ? '0 : r_cursor + AW'(1);
        w_cur_prev  = (r_cursor == '0) ? LAST_SLOT : r_cursor - AW'(1);
        w_sum_r = SW'(r_left) + SW'(w_cnt_m1);
        if (w_sum_r >= SW'(CAPACITY)) begin
            w_sum_r = w_sum_r - SW'(CAPACITY);
        end
        w_right      = w_sum_r[AW-1:0];
        w_right_prev = (w_right == '0) ? LAST_SLOT : w_right - AW'(1);
        w_sum_p = SW'(r_left) + SW'(r_count);
        if (w_sum_p >= SW'(CAPACITY)) begin
            w_sum_p = w_sum_p - SW'(CAPACITY);
        end
        w_push_r = w_sum_p[AW-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_take) n_state = S_FILL;
            S_FILL: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_idle      = (r_state == S_IDLE);
        o_res_valid = (r_state == S_FILL);
    end

    always_comb begin
        n_left   = r_left;
        n_cursor = r_cursor;
        n_count  = r_count;
        n_wl     = r_wl;
        n_wr     = r_wr;
        n_wc     = r_wc;
        n_popped = r_popped;
        n_status = r_status;
        n_ld_l   = r_ld_l;
        n_ld_r   = r_ld_r;
        n_ld_c   = r_ld_c;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = i_val;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        if (i_take) begin
            n_popped = '0;
            n_status = STAT_DONE;
            n_ld_l   = 1'b0;
            n_ld_r   = 1'b0;
            n_ld_c   = 1'b0;
            unique case (t_cmd'(i_cmd)) inside
                CMD_PUSH_L, CMD_PUSH_R: begin
                    if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        o_wr_en = 1'b1;
                        if (w_empty) begin
                            o_wr_addr = r_left;
                            n_cursor  = r_left;
                            n_wl      = i_val;
                            n_wr      = i_val;
                            n_wc      = i_val;
                        end else if (t_cmd'(i_cmd) == CMD_PUSH_L) begin
                            o_wr_addr = w_left_prev;
                            n_left    = w_left_prev;
                            n_wl      = i_val;
                        end else begin
                            o_wr_addr = w_push_r;
                            n_wr      = i_val;
                        end
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_POP_L: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_popped = r_wl;
                        if (r_count > CW'(1)) begin
                            n_left    = w_left_next;
                            o_rd_en   = 1'b1;
                            o_rd_addr = w_left_next;
                            n_ld_l    = 1'b1;
                            if (r_cursor == r_left) begin
                                n_cursor = w_left_next;
                                n_ld_c   = 1'b1;
                            end
                        end
                        n_count = w_cnt_m1;
                    end
                end
                CMD_POP_R: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_popped = r_wr;
                        if (r_count > CW'(1)) begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = w_right_prev;
                            n_ld_r    = 1'b1;
                            if (r_cursor == w_right) begin
                                n_cursor = w_right_prev;
                                n_ld_c   = 1'b1;
                            end
                        end
                        n_count = w_cnt_m1;
                    end
                end
                CMD_CUR_L: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else if (r_cursor == r_left) begin
                        n_status = STAT_AT_END;
                    end else begin
                        n_cursor  = w_cur_prev;
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_cur_prev;
                        n_ld_c    = 1'b1;
                    end
                end
                CMD_CUR_R: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else if (r_cursor == w_right) begin
                        n_status = STAT_AT_END;
                    end else begin
                        n_cursor  = w_cur_next;
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_cur_next;
                        n_ld_c    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == S_FILL) begin
            if (r_ld_l) n_wl = i_rd_data;
            if (r_ld_r) n_wr = i_rd_data;
            if (r_ld_c) n_wc = i_rd_data;
        end
    end

    always_comb begin
        o_count      = r_count;
        o_res.popped = r_popped;
        o_res.status = r_status;
        o_res.empty  = (r_count == '0);
        o_res.left   = o_res.empty ? '0 : n_wl;
        o_res.right  = o_res.empty ? '0 : n_wr;
        o_res.cursor = o_res.empty ? '0 : n_wc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_left   <= '0;
            r_cursor <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_left   <= n_left;
            r_cursor <= n_cursor;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wl     <= n_wl;
        r_wr     <= n_wr;
        r_wc     <= n_wc;
        r_popped <= n_popped;
        r_status <= n_status;
        r_ld_l   <= n_ld_l;
        r_ld_r   <= n_ld_r;
        r_ld_c   <= n_ld_c;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("held count above capacity");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left <= LAST_SLOT) && (r_cursor <= LAST_SLOT))
        else $error("slot index out of range");

    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("write and read issued together");

    a_fill_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |=> (r_state == S_IDLE))
        else $error("fill cycle not followed by idle");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> (r_state == S_IDLE))
        else $error("command taken while busy");

endmodule

FILE: rtl/double_ended_queue_with_cursor_core.sv
// Top level of the deque-with-cursor block: stream ports, result register.
// Depends on dqc_pkg, dqc_store and dqc_ctrl.
//
//  channel   dir  payload                                              handshake
//  s_axis    in   tuser: command[2:0]; tdata: push_value[31:0]         tvalid/tready
//  m_axis    out  tdata: popped_value, status, left_value, right_value, tvalid/tready
//                 cursor_value, entry_count, is_empty
//
// A word is accepted in the idle state, which issues the memory write or read;
// the fill state that follows loads the result register from the read data.
// s_axis_tready is high when the sequencer is idle and the result register is empty
// or drained in the same cycle.
// Reset clears slots, count, cursor and valid flags; the word memory is not cleared.
// A stall on m_axis holds the result and blocks the next command.
module double_ended_queue_with_cursor_core
    import dqc_pkg::*;
#(
    parameter int CAPACITY = DQC_CAPACITY,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int TDATA_W  = ((3 * WORD_W + WORD_W + 3 + CW + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [WORD_W-1:0]   s_axis_tdata,   // push_value
    input  logic [2:0]          s_axis_tuser,   // command
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // popped_value, status, left_value, right_value, cursor_value, entry_count,
    // is_empty, zero fill
    output logic [TDATA_W-1:0]  m_axis_tdata
);

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FLD_W  = 4 * WORD_W + 3 + CW;

    logic                     w_take;
    logic                     w_idle;
    logic                     w_res_valid;
    t_res                     w_res;
    logic [CW-1:0]            w_count;
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic signed [WORD_W-1:0] w_wr_data;
    logic                     w_rd_en;
    logic [AW-1:0]            w_rd_addr;
    logic signed [WORD_W-1:0] w_rd_data;
    logic [TDATA_W-1:0]       w_pack;

    logic                     r_m_valid, n_m_valid;
    logic [TDATA_W-1:0]       r_m_data;

    assign s_axis_tready = w_idle && (!r_m_valid || m_axis_tready);
    assign w_take        = s_axis_tvalid && s_axis_tready;

    dqc_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_cmd       (s_axis_tuser),
        .i_val       (s_axis_tdata),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_count     (w_count),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    dqc_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_pack = '0;
        w_pack[FLD_W-1:0] = {w_res.empty, w_count, w_res.cursor, w_res.right,
                             w_res.left, w_res.status, w_res.popped};
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (w_res_valid) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_data <= w_pack;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
